// ===== rtl/bounded_drop_queue_top_macros.svh =====
// Assertion macros for the bounded drop queue.
`ifndef BOUNDED_DROP_QUEUE_TOP_MACROS_SVH
`define BOUNDED_DROP_QUEUE_TOP_MACROS_SVH

`ifndef SYNTH
`define BDQ_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bdq same-cycle check failed");
`define BDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bdq next-cycle check failed");
`else
`define BDQ_ASSERT_SAME(label, clk, rst, ante, cons)
`define BDQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/bdq_pkg.sv =====
// Shared types and constants of the bounded drop queue.
package bdq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_LEN_W = 5;
  localparam int DATA_W = 32;
  localparam int SEQ_W = 32;
  localparam int CNT_OUT_W = 32;
  localparam logic [MAX_LEN_W-1:0] MAX_LENGTH_RESET = 5'd10;

  typedef enum logic {
    REQ_ADD  = 1'b0,
    REQ_TAKE = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_DROPPED = 2'd1,
    ST_TAKEN   = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

endpackage

// ===== rtl/bdq_if.sv =====
// Handshake channel interfaces of the bounded drop queue.
interface bdq_req_if import bdq_pkg::*; ();
  logic              valid;
  logic              ready;
  req_type_t         req_type;
  logic [DATA_W-1:0] entry_data;

  modport source (output valid, req_type, entry_data, input ready);
  modport sink (input valid, req_type, entry_data, output ready);
endinterface

interface bdq_rsp_if import bdq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [DATA_W-1:0]    out_data;
  logic [SEQ_W-1:0]     out_sequence;
  logic [MAX_LEN_W-1:0] queue_length;
  logic                 has_entry;
  logic [CNT_OUT_W-1:0] processed_count;
  logic [CNT_OUT_W-1:0] dropped_count;

  modport source (output valid, status, out_data, out_sequence, queue_length, has_entry,
                  processed_count, dropped_count, input ready);
  modport sink (input valid, status, out_data, out_sequence, queue_length, has_entry,
                processed_count, dropped_count, output ready);
endinterface

interface bdq_cfg_if import bdq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MAX_LEN_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/bounded_drop_queue_top.sv =====
// Bounded drop queue: a FIFO of entry handles with a configurable fill limit and tail drop.
// The block takes one request per clock cycle while no result waits for ready.
// A request is captured in an input register, processed against the queue pointers, counters
// and the slot memory when the result register can load, and its result is registered and
// presented from the result register. A result that waits for ready holds the input
// register, which then holds the request port. The single slot memory port pair (one write
// for an add, one registered read for a take) sets the rate at one request per cycle while
// no result waits for ready. Configuration writes are always accepted.
`include "bounded_drop_queue_top_macros.svh"

module bounded_drop_queue_top import bdq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input logic      clk,
  input logic      rst,
  bdq_cfg_if.sink  cfg,
  bdq_req_if.sink  req,
  bdq_rsp_if.source rsp
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > MAX_LEN_W) ? CNT_W : MAX_LEN_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(QUEUE_DEPTH);

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [SEQ_W-1:0]  seq;
  } slot_t;

  slot_t slot_mem [QUEUE_DEPTH];
  slot_t rd_slot;

  logic [MAX_LEN_W-1:0] max_length;
  logic [IDX_W-1:0]     head;
  logic [IDX_W-1:0]     tail;
  logic [CNT_W-1:0]     fill;
  logic [SEQ_W-1:0]     next_seq;
  logic [CNT_OUT_W-1:0] processed_total;
  logic [CNT_OUT_W-1:0] dropped_total;

  logic              a_valid;
  req_type_t         a_req;
  logic [DATA_W-1:0] a_data;

  logic             b_valid;
  status_t          b_status;
  logic [SEQ_W-1:0] b_seq;

  logic             b_load;
  logic             proc;
  logic             is_add;
  logic             can_add;
  logic             can_take;
  logic [CMP_W-1:0] fill_ext;
  logic [CMP_W-1:0] ml_ext;
  logic [CMP_W-1:0] limit;

  assign cfg.ready = 1'b1;

  assign b_load    = !b_valid || rsp.ready;
  assign proc      = a_valid && b_load;
  assign req.ready = !a_valid || b_load;

  assign fill_ext = CMP_W'(fill);
  assign ml_ext   = CMP_W'(max_length);
  assign limit    = (ml_ext > DEPTH_C) ? DEPTH_C : ml_ext;
  assign is_add   = (a_req == REQ_ADD);
  assign can_add  = fill_ext < limit;
  assign can_take = fill != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg.valid) begin
      max_length <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (req.ready) begin
      a_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      a_req  <= req.req_type;
      a_data <= req.entry_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head            <= '0;
      tail            <= '0;
      fill            <= '0;
      next_seq        <= '0;
      processed_total <= '0;
      dropped_total   <= '0;
    end else if (proc) begin
      if (is_add) begin
        processed_total <= processed_total + 1'b1;
        if (can_add) begin
          next_seq <= next_seq + 1'b1;
          tail     <= (tail == LAST_IDX) ? '0 : tail + 1'b1;
          fill     <= fill + 1'b1;
        end else begin
          dropped_total <= dropped_total + 1'b1;
        end
      end else if (can_take) begin
        head <= (head == LAST_IDX) ? '0 : head + 1'b1;
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc && is_add && can_add) begin
      slot_mem[tail] <= '{data: a_data, seq: next_seq};
    end
  end

  always_ff @(posedge clk) begin
    if (proc && !is_add) begin
      rd_slot <= slot_mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_load) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      b_seq <= next_seq;
      if (is_add) begin
        b_status <= can_add ? ST_ADDED : ST_DROPPED;
      end else begin
        b_status <= can_take ? ST_TAKEN : ST_EMPTY;
      end
    end
  end

  always_comb begin
    rsp.out_data     = '0;
    rsp.out_sequence = '0;
    case (b_status)
      ST_ADDED: begin
        rsp.out_sequence = b_seq;
      end
      ST_TAKEN: begin
        rsp.out_data     = rd_slot.data;
        rsp.out_sequence = rd_slot.seq;
      end
      default: begin
        rsp.out_data     = '0;
        rsp.out_sequence = '0;
      end
    endcase
  end

  assign rsp.valid           = b_valid;
  assign rsp.status          = b_status;
  assign rsp.queue_length    = fill_ext[MAX_LEN_W-1:0];
  assign rsp.has_entry       = can_take;
  assign rsp.processed_count = processed_total;
  assign rsp.dropped_count   = dropped_total;

  `BDQ_ASSERT_SAME(a_empty_ptrs, clk, rst, fill == '0, head == tail)
  `BDQ_ASSERT_SAME(a_fill_bound, clk, rst, 1'b1, fill_ext <= DEPTH_C)
  `BDQ_ASSERT_NEXT(a_drop_seq, clk, rst, proc && is_add && !can_add, next_seq == $past(next_seq))
  `BDQ_ASSERT_NEXT(a_add_seq, clk, rst, proc && is_add && can_add,
                   next_seq == $past(next_seq) + 1'b1)
  `BDQ_ASSERT_NEXT(a_proc_result, clk, rst, proc, b_valid)

endmodule
